// ----- src/hsl_to_rgb_converter_macros.svh -----
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define HSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hsl_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Widths, fixed-point constants, sector codes and pipeline control type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

  localparam int unsigned HueW          = 13;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned ChanMax       = 255;
  localparam int unsigned HueFull       = 5760;
  localparam int unsigned HueSector     = 960;
  localparam int unsigned HueTwoSectors = 2 * HueSector;

  // Chroma numerator (1/255^2), sector distance (1/960), products and sums.
  localparam int unsigned CnW   = 16;
  localparam int unsigned DistW = 10;
  localparam int unsigned AW    = 17;
  localparam int unsigned XpW   = 26;
  localparam int unsigned VxW   = 27;

  // Channel = v / Div, done as (v * Recip) >> Shift plus one correction step.
  localparam int unsigned DivC   = 510;
  localparam int unsigned DivX   = 244800;
  localparam int unsigned ShiftC = 17;
  localparam int unsigned ShiftX = 28;
  localparam int unsigned RecipC = (1 << ShiftC) / DivC;
  localparam int unsigned RecipX = (1 << ShiftX) / DivX;
  localparam int unsigned PcW    = AW + 9;
  localparam int unsigned PxW    = VxW + 11;
  localparam int unsigned QcW    = PcW - ShiftC;
  localparam int unsigned QxW    = PxW - ShiftX;
  localparam int unsigned QW     = 11;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned Latency = 5;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  typedef struct packed {
    logic    valid;
    sector_e sector;
  } hsl_ctrl_t;

endpackage

`default_nettype wire

// ----- src/hsl_scale.sv -----
// ----------------------------------------------------------------------------
// HSL channel scaler
// Divides the three channel numerators by their constant denominators,
// clamps to 8 bits and applies the sector permutation. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsl_to_rgb_converter_macros.svh"

module hsl_scale (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hsl_pkg::hsl_ctrl_t        ctrl_i,
  input  wire logic [hsl_pkg::AW-1:0]    vc_i,
  input  wire logic [hsl_pkg::AW-1:0]    vz_i,
  input  wire logic [hsl_pkg::VxW-1:0]   vx_i,
  output logic                           valid_o,
  output logic [hsl_pkg::ChanW-1:0]      red_o,
  output logic [hsl_pkg::ChanW-1:0]      green_o,
  output logic [hsl_pkg::ChanW-1:0]      blue_o
);

  function automatic logic [hsl_pkg::ChanW-1:0] sat8(input logic [hsl_pkg::QW-1:0] v);
    logic [hsl_pkg::ChanW-1:0] r;
    if (v > hsl_pkg::QW'(hsl_pkg::ChanMax)) begin
      r = hsl_pkg::ChanW'(hsl_pkg::ChanMax);
    end else begin
      r = v[hsl_pkg::ChanW-1:0];
    end
    return r;
  endfunction

  // Stage 4: reciprocal multiply, quotient estimate low by at most one.
  logic [hsl_pkg::PcW-1:0]  prod_c, prod_z;
  logic [hsl_pkg::PxW-1:0]  prod_x;

  logic                     v4_q;
  hsl_pkg::sector_e         sec4_q;
  logic [hsl_pkg::QcW-1:0]  qc4_q, qz4_q;
  logic [hsl_pkg::QxW-1:0]  qx4_q;
  logic [hsl_pkg::AW-1:0]   vc4_q, vz4_q;
  logic [hsl_pkg::VxW-1:0]  vx4_q;

  assign prod_c = hsl_pkg::PcW'(vc_i) * hsl_pkg::PcW'(hsl_pkg::RecipC);
  assign prod_z = hsl_pkg::PcW'(vz_i) * hsl_pkg::PcW'(hsl_pkg::RecipC);
  assign prod_x = hsl_pkg::PxW'(vx_i) * hsl_pkg::PxW'(hsl_pkg::RecipX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sec4_q <= ctrl_i.sector;
    qc4_q  <= prod_c[hsl_pkg::PcW-1:hsl_pkg::ShiftC];
    qz4_q  <= prod_z[hsl_pkg::PcW-1:hsl_pkg::ShiftC];
    qx4_q  <= prod_x[hsl_pkg::PxW-1:hsl_pkg::ShiftX];
    vc4_q  <= vc_i;
    vz4_q  <= vz_i;
    vx4_q  <= vx_i;
  end

  // Stage 5: remainder check, bump quotient, clamp, permute.
  logic [hsl_pkg::AW-1:0]    rc, rz;
  logic [hsl_pkg::VxW-1:0]   rx;
  logic [hsl_pkg::QW-1:0]    qc, qz, qx;
  logic [hsl_pkg::ChanW-1:0] chan_c, chan_z, chan_x;
  logic [hsl_pkg::ChanW-1:0] red_d, green_d, blue_d;
  logic                      valid_q;

  assign rc = vc4_q - hsl_pkg::AW'(hsl_pkg::AW'(qc4_q) * hsl_pkg::AW'(hsl_pkg::DivC));
  assign rz = vz4_q - hsl_pkg::AW'(hsl_pkg::AW'(qz4_q) * hsl_pkg::AW'(hsl_pkg::DivC));
  assign rx = vx4_q - hsl_pkg::VxW'(hsl_pkg::VxW'(qx4_q) * hsl_pkg::VxW'(hsl_pkg::DivX));

  assign qc = hsl_pkg::QW'(qc4_q) + hsl_pkg::QW'(rc >= hsl_pkg::AW'(hsl_pkg::DivC));
  assign qz = hsl_pkg::QW'(qz4_q) + hsl_pkg::QW'(rz >= hsl_pkg::AW'(hsl_pkg::DivC));
  assign qx = hsl_pkg::QW'(qx4_q) + hsl_pkg::QW'(rx >= hsl_pkg::VxW'(hsl_pkg::DivX));

  assign chan_c = sat8(qc);
  assign chan_z = sat8(qz);
  assign chan_x = sat8(qx);

  always_comb begin
    case (sec4_q)
      hsl_pkg::SecRed: begin
        red_d = chan_c; green_d = chan_x; blue_d = chan_z;
      end
      hsl_pkg::SecYellow: begin
        red_d = chan_x; green_d = chan_c; blue_d = chan_z;
      end
      hsl_pkg::SecGreen: begin
        red_d = chan_z; green_d = chan_c; blue_d = chan_x;
      end
      hsl_pkg::SecCyan: begin
        red_d = chan_z; green_d = chan_x; blue_d = chan_c;
      end
      hsl_pkg::SecBlue: begin
        red_d = chan_x; green_d = chan_z; blue_d = chan_c;
      end
      default: begin
        red_d = chan_c; green_d = chan_z; blue_d = chan_x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_o   <= red_d;
    green_o <= green_d;
    blue_o  <= blue_d;
  end

  assign valid_o = valid_q;

  // Secondary component lies between the zero and chroma components.
  `HSL_ASSERT_IMPL(a_chan_order, v4_q, (qc >= qx) && (qx >= qz), "channel order broken")
  // Corrected quotient never needs the clamp.
  `HSL_ASSERT_IMPL(a_no_clamp, v4_q, (qc <= hsl_pkg::QW'(hsl_pkg::ChanMax)) && (qx <= hsl_pkg::QW'(hsl_pkg::ChanMax)), "quotient above 255")
  // The valid bit advances into the output register.
  `HSL_ASSERT_NEXT(a_valid_adv, v4_q, valid_q, "valid bit dropped")

endmodule

`default_nettype wire

// ----- src/hsl_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Converts hue (1/16 degree), saturation and lightness (unsigned 8-bit, 255 = 1.0) to 8-bit RGB.
// ----------------------------------------------------------------------------
//  channel   signals                                 direction
//  request   start_i, busy_o, hue_i, saturation_i,   in
//            lightness_i
//  result    valid_o, red_o, green_o, blue_o         out
//
//  One request per cycle; busy_o stays low. Each result comes out of five
//  register stages: chroma, offset and
//  secondary products, secondary sum, reciprocal multiply, and divide
//  correction into the output register.
//  Results show for exactly one cycle; the receiver cannot stall.
//  Reset clears the stage valid bits only, so requests in flight are lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [hsl_pkg::HueW-1:0]    hue_i,
  input  wire logic [hsl_pkg::ChanW-1:0]   saturation_i,
  input  wire logic [hsl_pkg::ChanW-1:0]   lightness_i,
  output logic                             valid_o,
  output logic [hsl_pkg::ChanW-1:0]        red_o,
  output logic [hsl_pkg::ChanW-1:0]        green_o,
  output logic [hsl_pkg::ChanW-1:0]        blue_o
);

  assign busy_o = 1'b0;

  // Stage 1: hue wrap, sector, distance, chroma numerator.
  logic [hsl_pkg::HueW-1:0]    h_w;
  logic [hsl_pkg::HueW-2:0]    pos;
  logic [hsl_pkg::DistW-1:0]   dist_d;
  logic [hsl_pkg::ChanW:0]     twol;
  logic [hsl_pkg::ChanW-1:0]   absl, comp_l;
  logic [hsl_pkg::CnW-1:0]     cn_d;
  hsl_pkg::sector_e            sec_d;

  always_comb begin
    if (hue_i >= hsl_pkg::HueW'(hsl_pkg::HueFull)) begin
      h_w = hue_i - hsl_pkg::HueW'(hsl_pkg::HueFull);
    end else begin
      h_w = hue_i;
    end

    if (h_w >= hsl_pkg::HueW'(2 * hsl_pkg::HueTwoSectors)) begin
      pos = (hsl_pkg::HueW-1)'(h_w - hsl_pkg::HueW'(2 * hsl_pkg::HueTwoSectors));
    end else if (h_w >= hsl_pkg::HueW'(hsl_pkg::HueTwoSectors)) begin
      pos = (hsl_pkg::HueW-1)'(h_w - hsl_pkg::HueW'(hsl_pkg::HueTwoSectors));
    end else begin
      pos = (hsl_pkg::HueW-1)'(h_w);
    end

    if (pos >= (hsl_pkg::HueW-1)'(hsl_pkg::HueSector)) begin
      dist_d = hsl_pkg::DistW'((hsl_pkg::HueW-1)'(hsl_pkg::HueTwoSectors) - pos);
    end else begin
      dist_d = hsl_pkg::DistW'(pos);
    end

    if (h_w < hsl_pkg::HueW'(hsl_pkg::HueSector)) begin
      sec_d = hsl_pkg::SecRed;
    end else if (h_w < hsl_pkg::HueW'(2 * hsl_pkg::HueSector)) begin
      sec_d = hsl_pkg::SecYellow;
    end else if (h_w < hsl_pkg::HueW'(3 * hsl_pkg::HueSector)) begin
      sec_d = hsl_pkg::SecGreen;
    end else if (h_w < hsl_pkg::HueW'(4 * hsl_pkg::HueSector)) begin
      sec_d = hsl_pkg::SecCyan;
    end else if (h_w < hsl_pkg::HueW'(5 * hsl_pkg::HueSector)) begin
      sec_d = hsl_pkg::SecBlue;
    end else begin
      sec_d = hsl_pkg::SecMagenta;
    end

    twol = {lightness_i, 1'b0};
    if (twol >= (hsl_pkg::ChanW+1)'(hsl_pkg::ChanMax)) begin
      absl = hsl_pkg::ChanW'(twol - (hsl_pkg::ChanW+1)'(hsl_pkg::ChanMax));
    end else begin
      absl = hsl_pkg::ChanW'((hsl_pkg::ChanW+1)'(hsl_pkg::ChanMax) - twol);
    end
    comp_l = hsl_pkg::ChanW'(hsl_pkg::ChanMax) - absl;
    cn_d   = hsl_pkg::CnW'(comp_l) * hsl_pkg::CnW'(saturation_i);
  end

  logic                       v1_q;
  hsl_pkg::sector_e           sec1_q;
  logic [hsl_pkg::CnW-1:0]    cn1_q;
  logic [hsl_pkg::DistW-1:0]  dist1_q;
  logic [hsl_pkg::ChanW-1:0]  l1_q;

  // Stage 2: offset term a = 510*l - cn, chroma sum, secondary product.
  logic [hsl_pkg::AW-1:0]     l510, a_d, c_d;
  logic [hsl_pkg::XpW-1:0]    xp_d;

  assign l510 = hsl_pkg::AW'(l1_q) * hsl_pkg::AW'(hsl_pkg::DivC);
  assign a_d  = l510 - hsl_pkg::AW'(cn1_q);
  assign c_d  = l510 + hsl_pkg::AW'(cn1_q);
  assign xp_d = hsl_pkg::XpW'(cn1_q) * hsl_pkg::XpW'(dist1_q);

  logic                       v2_q;
  hsl_pkg::sector_e           sec2_q;
  logic [hsl_pkg::AW-1:0]     a2_q, c2_q;
  logic [hsl_pkg::XpW-1:0]    xp2_q;

  // Stage 3: secondary numerator over 2*255*480.
  logic [hsl_pkg::VxW-1:0]    vx_d;

  assign vx_d = hsl_pkg::VxW'(xp2_q)
              + hsl_pkg::VxW'(a2_q) * hsl_pkg::VxW'(hsl_pkg::HueSector / 2);

  logic                       v3_q;
  hsl_pkg::sector_e           sec3_q;
  hsl_pkg::hsl_ctrl_t         ctrl3;
  logic [hsl_pkg::AW-1:0]     vc3_q, vz3_q;
  logic [hsl_pkg::VxW-1:0]    vx3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec1_q  <= sec_d;
    cn1_q   <= cn_d;
    dist1_q <= dist_d;
    l1_q    <= lightness_i;
    sec2_q  <= sec1_q;
    a2_q    <= a_d;
    c2_q    <= c_d;
    xp2_q   <= xp_d;
    sec3_q  <= sec2_q;
    vc3_q   <= c2_q;
    vz3_q   <= a2_q;
    vx3_q   <= vx_d;
  end

  assign ctrl3.valid  = v3_q;
  assign ctrl3.sector = sec3_q;

  hsl_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl3),
    .vc_i    (vc3_q),
    .vz_i    (vz3_q),
    .vx_i    (vx3_q),
    .valid_o (valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  // A result strobe always traces back to a request.
  `HSL_ASSERT_IMPL(a_strobe_src, valid_o, $past(start_i, hsl_pkg::Latency), "result without request")
  // Zero saturation gives gray.
  `HSL_ASSERT_IMPL(a_gray, valid_o && ($past(saturation_i, hsl_pkg::Latency) == '0), (red_o == green_o) && (green_o == blue_o), "gray not equal")
  // Full lightness gives white.
  `HSL_ASSERT_IMPL(a_white, valid_o && ($past(lightness_i, hsl_pkg::Latency) == '1), (red_o == '1) && (green_o == '1) && (blue_o == '1), "white not full")

endmodule

`default_nettype wire

// ----- tb/hsl_to_rgb_converter_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSL to RGB converter checker
// Watches the request and result ports and predicts RGB for each accepted
// request. Compares every result strobe field by field against the oldest
// prediction and counts the failures.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic [hsl_pkg::HueW-1:0]             hue_i,
  input  logic [hsl_pkg::ChanW-1:0]            saturation_i,
  input  logic [hsl_pkg::ChanW-1:0]            lightness_i,
  input  logic                                 valid_i,
  input  logic [hsl_pkg::ChanW-1:0]            red_i,
  input  logic [hsl_pkg::ChanW-1:0]            green_i,
  input  logic [hsl_pkg::ChanW-1:0]            blue_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);

  typedef struct packed {
    logic [hsl_pkg::ChanW-1:0] red;
    logic [hsl_pkg::ChanW-1:0] green;
    logic [hsl_pkg::ChanW-1:0] blue;
  } rgb_t;

  // Common denominator of all channel sums after scaling by 255.
  localparam longint unsigned ChanDiv = 2 * hsl_pkg::ChanMax * hsl_pkg::HueSector;

  rgb_t rgb_due [$];
  int unsigned fail_count;

  function automatic rgb_t predict_rgb(logic [hsl_pkg::HueW-1:0] hue,
                                       logic [hsl_pkg::ChanW-1:0] sat,
                                       logic [hsl_pkg::ChanW-1:0] lum);
    longint unsigned h, s, l, twol, absl, chroma, pos, sec_dist;
    longint unsigned c_num, x_num, m_num, v;
    longint unsigned comp [3];
    hsl_pkg::sector_e sec;
    rgb_t res;
    h = hue;
    s = sat;
    l = lum;
    // Wrap one turn for hue at or beyond 360 degrees.
    if (h >= hsl_pkg::HueFull) h = h - hsl_pkg::HueFull;
    twol     = 2 * l;
    absl     = (twol >= hsl_pkg::ChanMax) ? (twol - hsl_pkg::ChanMax)
                                          : (hsl_pkg::ChanMax - twol);
    chroma   = (hsl_pkg::ChanMax - absl) * s;
    pos      = h % hsl_pkg::HueTwoSectors;
    sec_dist = hsl_pkg::HueSector - ((pos >= hsl_pkg::HueSector) ?
                                     (pos - hsl_pkg::HueSector) :
                                     (hsl_pkg::HueSector - pos));
    c_num    = chroma * 2 * hsl_pkg::HueSector;
    x_num    = chroma * sec_dist * 2;
    m_num    = l * 2 * hsl_pkg::ChanMax * hsl_pkg::HueSector - chroma * hsl_pkg::HueSector;
    sec      = hsl_pkg::sector_e'(h / hsl_pkg::HueSector);
    case (sec)
      hsl_pkg::SecRed: begin
        comp[0] = c_num; comp[1] = x_num; comp[2] = 0;
      end
      hsl_pkg::SecYellow: begin
        comp[0] = x_num; comp[1] = c_num; comp[2] = 0;
      end
      hsl_pkg::SecGreen: begin
        comp[0] = 0; comp[1] = c_num; comp[2] = x_num;
      end
      hsl_pkg::SecCyan: begin
        comp[0] = 0; comp[1] = x_num; comp[2] = c_num;
      end
      hsl_pkg::SecBlue: begin
        comp[0] = x_num; comp[1] = 0; comp[2] = c_num;
      end
      default: begin
        comp[0] = c_num; comp[1] = 0; comp[2] = x_num;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      v = (comp[k] + m_num) / ChanDiv;
      if (v > hsl_pkg::ChanMax) v = hsl_pkg::ChanMax;
      comp[k] = v;
    end
    res.red   = comp[0][hsl_pkg::ChanW-1:0];
    res.green = comp[1][hsl_pkg::ChanW-1:0];
    res.blue  = comp[2][hsl_pkg::ChanW-1:0];
    return res;
  endfunction

  task automatic check_chan(string chan, logic [hsl_pkg::ChanW-1:0] want,
                            logic [hsl_pkg::ChanW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (valid_i === 1'b1) begin
        if (rgb_due.size() == 0) begin
          $display("%0t: result with no request pending, actual %0d/%0d/%0d",
                   $time, red_i, green_i, blue_i);
          fail_count++;
        end else begin
          want = rgb_due.pop_front();
          check_chan("red", want.red, red_i);
          check_chan("green", want.green, green_i);
          check_chan("blue", want.blue, blue_i);
        end
      end
      if (start_i && busy_i === 1'b0)
        rgb_due.push_back(predict_rgb(hue_i, saturation_i, lightness_i));
    end
  end

  assign fail_count_o = fail_count;
  assign pending_o    = rgb_due.size();

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives directed corner colors and random requests with random gaps into
// the converter; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandomItems = 2000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [hsl_pkg::HueW-1:0]     hue_i;
  logic [hsl_pkg::ChanW-1:0]    saturation_i;
  logic [hsl_pkg::ChanW-1:0]    lightness_i;
  logic                         valid_o;
  logic [hsl_pkg::ChanW-1:0]    red_o;
  logic [hsl_pkg::ChanW-1:0]    green_o;
  logic [hsl_pkg::ChanW-1:0]    blue_o;
  int unsigned                  fail_count;
  int unsigned                  pending;
  int unsigned                  burst_left;

  hsl_to_rgb_converter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  hsl_to_rgb_converter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .valid_i      (valid_o),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_color(logic [hsl_pkg::HueW-1:0] h, logic [hsl_pkg::ChanW-1:0] s,
                            logic [hsl_pkg::ChanW-1:0] l);
    start_i      <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    lightness_i  <= l;
    @(negedge clk_i);
    while (busy_o !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 55)      n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 96) n = $urandom_range(4, 10);
    else if (r < 98) n = $urandom_range(20, 60);
    else begin
      // Run back-to-back for a while.
      n = 0;
      burst_left = $urandom_range(20, 80);
    end
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [hsl_pkg::ChanW-1:0] pick_chan();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return hsl_pkg::ChanW'(hsl_pkg::ChanMax);
      2:       return hsl_pkg::ChanW'($urandom_range(126, 129));
      default: return hsl_pkg::ChanW'($urandom_range(0, hsl_pkg::ChanMax));
    endcase
  endfunction

  function automatic logic [hsl_pkg::HueW-1:0] pick_hue();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return hsl_pkg::HueW'($urandom_range(hsl_pkg::HueFull, (1 << hsl_pkg::HueW) - 1));
    else if (r < 5)
      return hsl_pkg::HueW'($urandom_range(0, 5) * hsl_pkg::HueSector
                            + $urandom_range(0, 2) + hsl_pkg::HueSector - 1);
    else
      return hsl_pkg::HueW'($urandom_range(0, hsl_pkg::HueFull - 1));
  endfunction

  initial begin
    logic [hsl_pkg::HueW-1:0] corner_hue [12];
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    lightness_i  = '0;
    burst_left   = 0;
    corner_hue   = '{0, 959, 960, 1919, 1920, 2880, 3840, 4800, 5759, 5760, 7000, 8191};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sector edges and wrapped hues at full saturation, mid lightness.
    foreach (corner_hue[i]) send_color(corner_hue[i], 8'd255, 8'd128);
    // Gray axis, lightness extremes and mixed mid-range colors.
    send_color(13'd0, 8'd0, 8'd0);
    send_color(13'd1000, 8'd0, 8'd255);
    send_color(13'd2500, 8'd0, 8'd77);
    send_color(13'd3000, 8'd255, 8'd0);
    send_color(13'd4000, 8'd255, 8'd255);
    send_color(13'd480, 8'd255, 8'd127);
    send_color(13'd1440, 8'd128, 8'd128);
    send_color(13'd5000, 8'd1, 8'd254);
    send_color(13'd8191, 8'd255, 8'd255);
    send_color(13'd4095, 8'd170, 8'd85);

    for (int i = 0; i < RandomItems; i++) begin
      idle_gap();
      send_color(pick_hue(), pick_chan(), pick_chan());
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (hsl_pkg::Latency + 4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
